### hdl/tfsr_pkg.sv
// Shared types, codes and fixed-point helpers of the tridiagonal reduction unit.
package tfsr_pkg;

  localparam int unsigned Q_W   = 32;
  localparam int unsigned SUM_W = 36;
  localparam int unsigned IDX_W = 3;

  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX - SUM_W'(64'sd1);
  localparam logic signed [63:0]      P_MAX   = 64'sd2147483647;
  localparam logic signed [63:0]      P_MIN   = -64'sd2147483648;

  typedef enum logic {
    OP_REDUCE  = 1'b0,
    OP_BACKSUB = 1'b1
  } op_t;

  typedef enum logic [IDX_W-1:0] {
    CFG_COEF_A      = 3'd0,
    CFG_COEF_B      = 3'd1,
    CFG_COEF_C      = 3'd2,
    CFG_FIRST_VALUE = 3'd3,
    CFG_LAST_VALUE  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    op_t                    opcode;
    logic signed [Q_W-1:0]  sample_0;
    logic signed [Q_W-1:0]  sample_1;
    logic signed [Q_W-1:0]  sample_2;
    logic signed [Q_W-1:0]  sample_3;
    logic signed [Q_W-1:0]  sample_4;
    logic signed [Q_W-1:0]  sample_5;
    logic signed [Q_W-1:0]  sample_6;
    logic signed [Q_W-1:0]  reduced_left;
    logic signed [Q_W-1:0]  reduced_right;
    logic                   at_first;
    logic                   at_last;
  } in_item_t;

  typedef struct packed {
    logic signed [Q_W-1:0]  value_0;
    logic signed [Q_W-1:0]  value_1;
    logic signed [Q_W-1:0]  value_2;
    logic signed [Q_W-1:0]  value_3;
    logic                   fault;
  } out_item_t;

  typedef struct packed {
    logic                   ovf;
    logic signed [Q_W-1:0]  val;
  } qres_t;

  function automatic qres_t qmul(input logic signed [Q_W-1:0] x,
                                 input logic signed [Q_W-1:0] y,
                                 input int unsigned fb);
    logic signed [63:0] p;
    logic signed [63:0] s;
    qres_t r;
    p = x * y;
    p = p + (64'sd1 <<< (fb - 1));
    s = p >>> fb;
    if (s > P_MAX) begin
      r.ovf = 1'b1;
      r.val = P_MAX[Q_W-1:0];
    end else if (s < P_MIN) begin
      r.ovf = 1'b1;
      r.val = P_MIN[Q_W-1:0];
    end else begin
      r.ovf = 1'b0;
      r.val = s[Q_W-1:0];
    end
    return r;
  endfunction

  function automatic qres_t qsat(input logic signed [SUM_W-1:0] s);
    qres_t r;
    if (s > SUM_MAX) begin
      r.ovf = 1'b1;
      r.val = SUM_MAX[Q_W-1:0];
    end else if (s < SUM_MIN) begin
      r.ovf = 1'b1;
      r.val = SUM_MIN[Q_W-1:0];
    end else begin
      r.ovf = 1'b0;
      r.val = s[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

### hdl/tfsr_lane.sv
// One stencil lane: a*x0 - b*x1 + c*x2, products then an exact sum.
module tfsr_lane import tfsr_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [Q_W-1:0]   coef_a,
  input  logic signed [Q_W-1:0]   coef_b,
  input  logic signed [Q_W-1:0]   coef_c,
  input  logic signed [Q_W-1:0]   x0,
  input  logic signed [Q_W-1:0]   x1,
  input  logic signed [Q_W-1:0]   x2,
  output logic signed [SUM_W-1:0] sum_o,
  output logic                    ovf_o
);

  qres_t p0_r, p1_r, p2_r;
  logic signed [SUM_W-1:0] sum_r;
  logic ovf_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r  <= qmul(coef_a, x0, FRACTION_BITS);
      p1_r  <= qmul(coef_b, x1, FRACTION_BITS);
      p2_r  <= qmul(coef_c, x2, FRACTION_BITS);
      sum_r <= SUM_W'($signed(p0_r.val)) - SUM_W'($signed(p1_r.val))
               + SUM_W'($signed(p2_r.val));
      ovf_r <= p0_r.ovf | p1_r.ovf | p2_r.ovf;
    end
  end

  assign sum_o = sum_r;
  assign ovf_o = ovf_r;

endmodule

### hdl/tfsr_div.sv
// Pipelined restoring divider, one quotient bit per stage, lanes sharing one divisor.
module tfsr_div import tfsr_pkg::*; #(
  parameter int FRACTION_BITS = 16,
  parameter int LANES         = 1,
  parameter int SIDE_W        = 1
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [LANES-1:0][Q_W-1:0]     num_i,
  input  logic signed [Q_W-1:0]         den_i,
  input  logic [SIDE_W-1:0]             side_i,
  output qres_t [LANES-1:0]             quo_o,
  output logic [SIDE_W-1:0]             side_o
);

  localparam int NW     = Q_W + FRACTION_BITS;
  localparam int STAGES = NW + 1;
  localparam logic [NW-1:0] POS_LIM = NW'(64'h7FFFFFFF);
  localparam logic [NW-1:0] NEG_LIM = NW'(64'h80000000);

  logic [NW-1:0]  dvd_r [LANES][STAGES];
  logic [Q_W:0]   rem_r [LANES][STAGES];
  logic [NW-1:0]  quo_r [LANES][STAGES];
  logic           neg_r [LANES][STAGES];
  logic [Q_W-1:0] dsr_r [STAGES];
  logic           zero_r [STAGES];
  logic [SIDE_W-1:0] side_r [STAGES];

  logic [Q_W-1:0] den_mag;
  assign den_mag = den_i[Q_W-1] ? (~den_i + 1'b1) : den_i;

  always_ff @(posedge clk) begin
    if (en) begin
      dsr_r[0]  <= den_mag;
      zero_r[0] <= (den_i == '0);
      side_r[0] <= side_i;
    end
  end

  for (genvar k = 1; k < STAGES; k++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (en) begin
        dsr_r[k]  <= dsr_r[k-1];
        zero_r[k] <= zero_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [Q_W-1:0] num_mag;
    assign num_mag = num_i[l][Q_W-1] ? (~num_i[l] + 1'b1) : num_i[l];

    always_ff @(posedge clk) begin
      if (en) begin
        dvd_r[l][0] <= {num_mag, {FRACTION_BITS{1'b0}}};
        rem_r[l][0] <= '0;
        quo_r[l][0] <= '0;
        neg_r[l][0] <= num_i[l][Q_W-1] ^ den_i[Q_W-1];
      end
    end

    for (genvar k = 1; k < STAGES; k++) begin : g_stage
      logic [Q_W:0] trial;
      logic         take;
      assign trial = {rem_r[l][k-1][Q_W-1:0], dvd_r[l][k-1][NW-1]};
      assign take  = (trial >= {1'b0, dsr_r[k-1]});
      always_ff @(posedge clk) begin
        if (en) begin
          dvd_r[l][k] <= {dvd_r[l][k-1][NW-2:0], 1'b0};
          rem_r[l][k] <= take ? (trial - {1'b0, dsr_r[k-1]}) : trial;
          quo_r[l][k] <= {quo_r[l][k-1][NW-2:0], take};
          neg_r[l][k] <= neg_r[l][k-1];
        end
      end
    end

    always_comb begin
      if (zero_r[STAGES-1]) begin
        quo_o[l].ovf = 1'b1;
        quo_o[l].val = '0;
      end else if (!neg_r[l][STAGES-1]) begin
        if (quo_r[l][STAGES-1] > POS_LIM) begin
          quo_o[l].ovf = 1'b1;
          quo_o[l].val = POS_LIM[Q_W-1:0];
        end else begin
          quo_o[l].ovf = 1'b0;
          quo_o[l].val = quo_r[l][STAGES-1][Q_W-1:0];
        end
      end else begin
        if (quo_r[l][STAGES-1] > NEG_LIM) begin
          quo_o[l].ovf = 1'b1;
          quo_o[l].val = NEG_LIM[Q_W-1:0];
        end else begin
          quo_o[l].ovf = 1'b0;
          quo_o[l].val = ~quo_r[l][STAGES-1][Q_W-1:0] + 1'b1;
        end
      end
    end
  end

  assign side_o = side_r[STAGES-1];

endmodule

### hdl/tridiagonal_four_step_reduction_unit.sv
// Top level of the tridiagonal four-step reduction unit.
//
//   channel   direction  handshake            payload
//   in_       input      in_valid / in_stall    in_item_t
//   out_      output     out_valid / out_stall  out_item_t
//   cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item is accepted per cycle while in_stall is low; the result path runs through
// the two serial bit-per-stage dividers (by t, then by b in two lanes).
// The pipeline advances whenever its last stage is empty or the output register
// can load, so input keeps flowing while a result waits on out_stall, until the last stage fills.
// Reset is synchronous; it clears the valid chain and loads the register defaults.
module tridiagonal_four_step_reduction_unit import tfsr_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [Q_W-1:0]       cfg_data
);

  localparam int DIV_LAT = Q_W + FRACTION_BITS + 1;
  localparam int DEPTH   = 8 + 2 * DIV_LAT;

  typedef struct packed {
    op_t                   op;
    logic signed [Q_W-1:0] d0;
    logic signed [Q_W-1:0] d4;
    logic signed [Q_W-1:0] s0;
    logic signed [Q_W-1:0] s2;
    logic signed [Q_W-1:0] ad0;
    logic signed [Q_W-1:0] cd4;
    logic signed [Q_W-1:0] rhs;
    logic signed [Q_W-1:0] a4;
    logic signed [Q_W-1:0] mid;
    logic signed [Q_W-1:0] c4;
    logic                  flag;
  } side1_t;

  typedef struct packed {
    op_t                   op;
    logic signed [Q_W-1:0] d0;
    logic signed [Q_W-1:0] d2;
    logic signed [Q_W-1:0] rhs;
    logic signed [Q_W-1:0] a4;
    logic signed [Q_W-1:0] mid;
    logic signed [Q_W-1:0] c4;
    logic                  flag;
  } side2_t;

  logic signed [Q_W-1:0] coef_a_r, coef_b_r, coef_c_r, first_r, last_r;
  logic [DEPTH-1:0] vld_r;
  logic out_valid_r;
  out_item_t out_data_r;
  logic en, o_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r <= '0;
      coef_b_r <= Q_W'(64'sd1 <<< FRACTION_BITS);
      coef_c_r <= '0;
      first_r  <= '0;
      last_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_COEF_A:      coef_a_r <= cfg_data;
        CFG_COEF_B:      coef_b_r <= cfg_data;
        CFG_COEF_C:      coef_c_r <= cfg_data;
        CFG_FIRST_VALUE: first_r  <= cfg_data;
        CFG_LAST_VALUE:  last_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign o_ready  = !out_valid_r || !out_stall;
  assign en       = !vld_r[DEPTH-1] || o_ready;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  // Stage 1: coefficient products and the three stencil lanes.
  op_t s1_op_r;
  logic signed [Q_W-1:0] s1_s0_r, s1_s2_r, s1_d0_r, s1_d4_r;
  logic s1_first_r, s1_last_r;
  qres_t s1_aa_r, s1_bb_r, s1_cc_r, s1_ac_r, s1_ad0_r, s1_cd4_r;
  logic signed [SUM_W-1:0] lane_sum [3];
  logic lane_ovf [3];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op_r    <= in_data.opcode;
      s1_s0_r    <= in_data.sample_0;
      s1_s2_r    <= in_data.sample_2;
      s1_d0_r    <= in_data.reduced_left;
      s1_d4_r    <= in_data.reduced_right;
      s1_first_r <= in_data.at_first;
      s1_last_r  <= in_data.at_last;
      s1_aa_r    <= qmul(coef_a_r, coef_a_r, FRACTION_BITS);
      s1_bb_r    <= qmul(coef_b_r, coef_b_r, FRACTION_BITS);
      s1_cc_r    <= qmul(coef_c_r, coef_c_r, FRACTION_BITS);
      s1_ac_r    <= qmul(coef_a_r, coef_c_r, FRACTION_BITS);
      s1_ad0_r   <= qmul(coef_a_r, in_data.reduced_left, FRACTION_BITS);
      s1_cd4_r   <= qmul(coef_c_r, in_data.reduced_right, FRACTION_BITS);
    end
  end

  tfsr_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane0 (
    .clk(clk), .en(en), .coef_a(coef_a_r), .coef_b(coef_b_r), .coef_c(coef_c_r),
    .x0(in_data.sample_0), .x1(in_data.sample_1), .x2(in_data.sample_2),
    .sum_o(lane_sum[0]), .ovf_o(lane_ovf[0])
  );

  tfsr_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane1 (
    .clk(clk), .en(en), .coef_a(coef_a_r), .coef_b(coef_b_r), .coef_c(coef_c_r),
    .x0(in_data.sample_2), .x1(in_data.sample_3), .x2(in_data.sample_4),
    .sum_o(lane_sum[1]), .ovf_o(lane_ovf[1])
  );

  tfsr_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane2 (
    .clk(clk), .en(en), .coef_a(coef_a_r), .coef_b(coef_b_r), .coef_c(coef_c_r),
    .x0(in_data.sample_4), .x1(in_data.sample_5), .x2(in_data.sample_6),
    .sum_o(lane_sum[2]), .ovf_o(lane_ovf[2])
  );

  // Stage 2: t and the fourth-power terms.
  qres_t s2_t_nxt;
  assign s2_t_nxt = qsat((SUM_W'($signed(s1_ac_r.val)) <<< 1) - SUM_W'($signed(s1_bb_r.val)));

  op_t s2_op_r;
  logic signed [Q_W-1:0] s2_s0_r, s2_s2_r, s2_d0_r, s2_d4_r, s2_aa_r, s2_cc_r, s2_t_r;
  logic signed [Q_W-1:0] s2_ad0_r, s2_cd4_r;
  logic s2_first_r, s2_last_r, s2_com_r, s2_bs_r;
  qres_t s2_a4_r, s2_c4_r, s2_aacc_r, s2_aad0_r, s2_ccd4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_op_r    <= s1_op_r;
      s2_s0_r    <= s1_s0_r;
      s2_s2_r    <= s1_s2_r;
      s2_d0_r    <= s1_d0_r;
      s2_d4_r    <= s1_d4_r;
      s2_first_r <= s1_first_r;
      s2_last_r  <= s1_last_r;
      s2_aa_r    <= s1_aa_r.val;
      s2_cc_r    <= s1_cc_r.val;
      s2_t_r     <= s2_t_nxt.val;
      s2_ad0_r   <= s1_ad0_r.val;
      s2_cd4_r   <= s1_cd4_r.val;
      s2_com_r   <= s1_aa_r.ovf | s1_bb_r.ovf | s1_cc_r.ovf | s1_ac_r.ovf | s2_t_nxt.ovf;
      s2_bs_r    <= s1_ad0_r.ovf | s1_cd4_r.ovf;
      s2_a4_r    <= qmul(s1_aa_r.val, s1_aa_r.val, FRACTION_BITS);
      s2_c4_r    <= qmul(s1_cc_r.val, s1_cc_r.val, FRACTION_BITS);
      s2_aacc_r  <= qmul(s1_aa_r.val, s1_cc_r.val, FRACTION_BITS);
      s2_aad0_r  <= qmul(s1_aa_r.val, s1_d0_r, FRACTION_BITS);
      s2_ccd4_r  <= qmul(s1_cc_r.val, s1_d4_r, FRACTION_BITS);
    end
  end

  // Stage 3: saturate the lanes, back-substitute numerator, t squared.
  qres_t s3_r1_nxt, s3_r3_nxt, s3_r5_nxt, s3_num_nxt;
  assign s3_r1_nxt  = qsat(lane_sum[0]);
  assign s3_r3_nxt  = qsat(lane_sum[1]);
  assign s3_r5_nxt  = qsat(lane_sum[2]);
  assign s3_num_nxt = qsat(lane_sum[0] - SUM_W'($signed(s2_aad0_r.val))
                           - SUM_W'($signed(s2_ccd4_r.val)));

  op_t s3_op_r;
  logic signed [Q_W-1:0] s3_s0_r, s3_s2_r, s3_d0_r, s3_d4_r, s3_aa_r, s3_cc_r, s3_t_r;
  logic signed [Q_W-1:0] s3_ad0_r, s3_cd4_r, s3_a4_r, s3_c4_r, s3_aacc_r;
  logic signed [Q_W-1:0] s3_r1_r, s3_r3_r, s3_r5_r, s3_num_r;
  logic s3_first_r, s3_last_r, s3_com_r, s3_bs_r, s3_red_r;
  qres_t s3_tt_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_op_r    <= s2_op_r;
      s3_s0_r    <= s2_s0_r;
      s3_s2_r    <= s2_s2_r;
      s3_d0_r    <= s2_d0_r;
      s3_d4_r    <= s2_d4_r;
      s3_aa_r    <= s2_aa_r;
      s3_cc_r    <= s2_cc_r;
      s3_t_r     <= s2_t_r;
      s3_ad0_r   <= s2_ad0_r;
      s3_cd4_r   <= s2_cd4_r;
      s3_a4_r    <= s2_a4_r.val;
      s3_c4_r    <= s2_c4_r.val;
      s3_aacc_r  <= s2_aacc_r.val;
      s3_first_r <= s2_first_r;
      s3_last_r  <= s2_last_r;
      s3_com_r   <= s2_com_r;
      s3_r1_r    <= s3_r1_nxt.val;
      s3_r3_r    <= s3_r3_nxt.val;
      s3_r5_r    <= s3_r5_nxt.val;
      s3_num_r   <= s3_num_nxt.val;
      s3_tt_r    <= qmul(s2_t_r, s2_t_r, FRACTION_BITS);
      s3_red_r   <= s2_a4_r.ovf | s2_c4_r.ovf | s2_aacc_r.ovf | lane_ovf[0] | lane_ovf[1]
                    | lane_ovf[2] | s3_r1_nxt.ovf | s3_r3_nxt.ovf | s3_r5_nxt.ovf;
      s3_bs_r    <= s2_bs_r | lane_ovf[0] | s2_aad0_r.ovf | s2_ccd4_r.ovf | s3_num_nxt.ovf;
    end
  end

  // Stage 4: right-side products, middle diagonal, boundary products.
  qres_t s4_mid_nxt;
  assign s4_mid_nxt = qsat((SUM_W'($signed(s3_aacc_r)) <<< 1) - SUM_W'($signed(s3_tt_r.val)));

  op_t s4_op_r;
  logic signed [Q_W-1:0] s4_s0_r, s4_s2_r, s4_d0_r, s4_d4_r, s4_t_r;
  logic signed [Q_W-1:0] s4_ad0_r, s4_cd4_r, s4_a4_r, s4_c4_r, s4_mid_r, s4_num_r;
  logic s4_first_r, s4_last_r, s4_com_r, s4_bs_r, s4_red_r;
  qres_t s4_aar1_r, s4_tr3_r, s4_ccr5_r, s4_fa_r, s4_fc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_op_r    <= s3_op_r;
      s4_s0_r    <= s3_s0_r;
      s4_s2_r    <= s3_s2_r;
      s4_d0_r    <= s3_d0_r;
      s4_d4_r    <= s3_d4_r;
      s4_t_r     <= s3_t_r;
      s4_ad0_r   <= s3_ad0_r;
      s4_cd4_r   <= s3_cd4_r;
      s4_a4_r    <= s3_a4_r;
      s4_c4_r    <= s3_c4_r;
      s4_mid_r   <= s4_mid_nxt.val;
      s4_num_r   <= s3_num_r;
      s4_first_r <= s3_first_r;
      s4_last_r  <= s3_last_r;
      s4_com_r   <= s3_com_r;
      s4_bs_r    <= s3_bs_r;
      s4_red_r   <= s3_red_r | s3_tt_r.ovf | s4_mid_nxt.ovf;
      s4_aar1_r  <= qmul(s3_aa_r, s3_r1_r, FRACTION_BITS);
      s4_tr3_r   <= qmul(s3_t_r, s3_r3_r, FRACTION_BITS);
      s4_ccr5_r  <= qmul(s3_cc_r, s3_r5_r, FRACTION_BITS);
      s4_fa_r    <= qmul(s3_a4_r, first_r, FRACTION_BITS);
      s4_fc_r    <= qmul(s3_c4_r, last_r, FRACTION_BITS);
    end
  end

  // Stage 5: reduced right-side entry.
  qres_t s5_rhs_nxt;
  assign s5_rhs_nxt = qsat(SUM_W'($signed(s4_aar1_r.val)) - SUM_W'($signed(s4_tr3_r.val))
                           + SUM_W'($signed(s4_ccr5_r.val)));

  op_t s5_op_r;
  logic signed [Q_W-1:0] s5_s0_r, s5_s2_r, s5_d0_r, s5_d4_r, s5_t_r;
  logic signed [Q_W-1:0] s5_ad0_r, s5_cd4_r, s5_a4_r, s5_c4_r, s5_mid_r, s5_num_r;
  logic signed [Q_W-1:0] s5_rhs_r, s5_fa_r, s5_fc_r;
  logic s5_first_r, s5_last_r, s5_com_r, s5_bs_r, s5_red_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_op_r    <= s4_op_r;
      s5_s0_r    <= s4_s0_r;
      s5_s2_r    <= s4_s2_r;
      s5_d0_r    <= s4_d0_r;
      s5_d4_r    <= s4_d4_r;
      s5_t_r     <= s4_t_r;
      s5_ad0_r   <= s4_ad0_r;
      s5_cd4_r   <= s4_cd4_r;
      s5_a4_r    <= s4_a4_r;
      s5_c4_r    <= s4_c4_r;
      s5_mid_r   <= s4_mid_r;
      s5_num_r   <= s4_num_r;
      s5_rhs_r   <= s5_rhs_nxt.val;
      s5_fa_r    <= s4_fa_r.val;
      s5_fc_r    <= s4_fc_r.val;
      s5_first_r <= s4_first_r;
      s5_last_r  <= s4_last_r;
      s5_com_r   <= s4_com_r;
      s5_bs_r    <= s4_bs_r;
      s5_red_r   <= s4_red_r | s4_aar1_r.ovf | s4_tr3_r.ovf | s4_ccr5_r.ovf | s5_rhs_nxt.ovf
                    | (s4_first_r & s4_fa_r.ovf) | (s4_last_r & s4_fc_r.ovf);
    end
  end

  // Stage 6: boundary corrections and flag merge.
  qres_t s6_rf, s6_rl;
  logic signed [Q_W-1:0] s6_x, s6_y;
  logic s6_red;
  side1_t s6_side_nxt;

  always_comb begin
    s6_rf  = qsat(SUM_W'($signed(s5_rhs_r)) - SUM_W'($signed(s5_fa_r)));
    s6_x   = s5_first_r ? s6_rf.val : s5_rhs_r;
    s6_rl  = qsat(SUM_W'($signed(s6_x)) - SUM_W'($signed(s5_fc_r)));
    s6_y   = s5_last_r ? s6_rl.val : s6_x;
    s6_red = s5_red_r | (s5_first_r & s6_rf.ovf) | (s5_last_r & s6_rl.ovf);
    s6_side_nxt.op   = s5_op_r;
    s6_side_nxt.d0   = s5_d0_r;
    s6_side_nxt.d4   = s5_d4_r;
    s6_side_nxt.s0   = s5_s0_r;
    s6_side_nxt.s2   = s5_s2_r;
    s6_side_nxt.ad0  = s5_ad0_r;
    s6_side_nxt.cd4  = s5_cd4_r;
    s6_side_nxt.rhs  = s6_y;
    s6_side_nxt.a4   = s5_a4_r;
    s6_side_nxt.mid  = s5_mid_r;
    s6_side_nxt.c4   = s5_c4_r;
    s6_side_nxt.flag = s5_com_r | ((s5_op_r == OP_REDUCE) ? s6_red : s5_bs_r);
  end

  side1_t s6_side_r;
  logic signed [Q_W-1:0] s6_num_r, s6_t_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_side_r <= s6_side_nxt;
      s6_num_r  <= s5_num_r;
      s6_t_r    <= s5_t_r;
    end
  end

  qres_t [0:0] d1_quo;
  side1_t d1_side;

  tfsr_div #(.FRACTION_BITS(FRACTION_BITS), .LANES(1), .SIDE_W($bits(side1_t))) u_div_t (
    .clk(clk), .en(en), .num_i(s6_num_r), .den_i(s6_t_r), .side_i(s6_side_r),
    .quo_o(d1_quo), .side_o(d1_side)
  );

  // Stage 7: products of the middle unknown.
  side1_t s7_side_nxt;
  side1_t s7_side_r;
  logic signed [Q_W-1:0] s7_d2_r;
  qres_t s7_ad2_r, s7_cd2_r;

  always_comb begin
    s7_side_nxt      = d1_side;
    s7_side_nxt.flag = d1_side.flag | ((d1_side.op == OP_BACKSUB) & d1_quo[0].ovf);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_side_r <= s7_side_nxt;
      s7_d2_r   <= d1_quo[0].val;
      s7_ad2_r  <= qmul(coef_a_r, d1_quo[0].val, FRACTION_BITS);
      s7_cd2_r  <= qmul(coef_c_r, d1_quo[0].val, FRACTION_BITS);
    end
  end

  // Stage 8: numerators of the two outer unknowns.
  qres_t s8_n1_nxt, s8_n3_nxt;
  side2_t s8_side_nxt;

  always_comb begin
    s8_n1_nxt = qsat(SUM_W'($signed(s7_side_r.s0)) - SUM_W'($signed(s7_side_r.ad0))
                     - SUM_W'($signed(s7_cd2_r.val)));
    s8_n3_nxt = qsat(SUM_W'($signed(s7_side_r.s2)) - SUM_W'($signed(s7_ad2_r.val))
                     - SUM_W'($signed(s7_side_r.cd4)));
    s8_side_nxt.op   = s7_side_r.op;
    s8_side_nxt.d0   = s7_side_r.d0;
    s8_side_nxt.d2   = s7_d2_r;
    s8_side_nxt.rhs  = s7_side_r.rhs;
    s8_side_nxt.a4   = s7_side_r.a4;
    s8_side_nxt.mid  = s7_side_r.mid;
    s8_side_nxt.c4   = s7_side_r.c4;
    s8_side_nxt.flag = s7_side_r.flag | ((s7_side_r.op == OP_BACKSUB)
                       & (s7_ad2_r.ovf | s7_cd2_r.ovf | s8_n1_nxt.ovf | s8_n3_nxt.ovf));
  end

  side2_t s8_side_r;
  logic [1:0][Q_W-1:0] s8_num_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_side_r   <= s8_side_nxt;
      s8_num_r[0] <= s8_n1_nxt.val;
      s8_num_r[1] <= s8_n3_nxt.val;
    end
  end

  qres_t [1:0] d2_quo;
  side2_t d2_side;

  tfsr_div #(.FRACTION_BITS(FRACTION_BITS), .LANES(2), .SIDE_W($bits(side2_t))) u_div_b (
    .clk(clk), .en(en), .num_i(s8_num_r), .den_i(coef_b_r), .side_i(s8_side_r),
    .quo_o(d2_quo), .side_o(d2_side)
  );

  out_item_t res_nxt;

  always_comb begin
    if (d2_side.op == OP_REDUCE) begin
      res_nxt.value_0 = d2_side.rhs;
      res_nxt.value_1 = d2_side.a4;
      res_nxt.value_2 = d2_side.mid;
      res_nxt.value_3 = d2_side.c4;
      res_nxt.fault   = d2_side.flag;
    end else begin
      res_nxt.value_0 = d2_side.d0;
      res_nxt.value_1 = d2_quo[0].val;
      res_nxt.value_2 = d2_side.d2;
      res_nxt.value_3 = d2_quo[1].val;
      res_nxt.fault   = d2_side.flag | d2_quo[0].ovf | d2_quo[1].ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (o_ready) begin
      out_valid_r <= vld_r[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
